[hw/rtl/sha_pkg.sv]
// Package: SHA-256 constants, types and round functions.
`default_nettype none
package sha_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef logic [31:0] word_type;
   typedef word_type    hash_type [8];

   // request and response payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // control from sequencer to the round unit
   typedef struct packed {
      logic start;   // copy chain into working vars, load schedule
      logic step;    // one round
      logic finish;  // fold working vars into chain
      logic reinit;  // back to initial hash
   } rnd_ctl_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage
`default_nettype wire

[hw/rtl/sha_if.sv]
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface sha_req_if;
   logic             valid;
   logic             ready;
   sha_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sha_rsp_if;
   logic             valid;
   logic             ready;
   sha_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/sha_round.sv]
// SHA-256 round unit: rolling 16-word schedule, working vars, chain words.
`default_nettype none
module sha_round (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sha_pkg::rnd_ctl_type ctl,
   input  wire logic [5:0]           round_idx,
   input  wire sha_pkg::word_type    block_words [16],
   input  wire logic [2:0]           rd_index,
   output      sha_pkg::word_type    rd_word
);
   sha_pkg::word_type sched_ff [16];
   sha_pkg::word_type vars_ff  [8];
   sha_pkg::word_type chain_ff [8];
   sha_pkg::word_type t1, t2, w_new;

   assign rd_word = chain_ff[rd_index];

   always_comb begin
      t1 = vars_ff[7] + sha_pkg::bsig1(vars_ff[4])
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
         + sha_pkg::ROUND_K[round_idx] + sched_ff[0];
      t2 = sha_pkg::bsig0(vars_ff[0])
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]));
      w_new = sched_ff[0] + sha_pkg::sig0(sched_ff[1]) + sched_ff[9]
            + sha_pkg::sig1(sched_ff[14]);
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         sched_ff <= block_words;
      end else if (ctl.step) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            vars_ff[i]  <= '0;
            chain_ff[i] <= sha_pkg::INIT_HASH[i];
         end
      end else if (ctl.start) begin
         vars_ff <= chain_ff;
      end else if (ctl.step) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end else if (ctl.finish) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + vars_ff[i];
      end else if (ctl.reinit) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha_pkg::INIT_HASH[i];
      end
   end
endmodule
`default_nettype wire

[hw/rtl/sha256_message_hasher.sv]
// Top level: byte-stream SHA-256 hasher with sequencer and block buffer.
//
// Usage:
//   req channel: one transaction per message byte (has_byte=1), last=1 ends
//   the message; has_byte=0,last=1 closes an empty message; has_byte=0,
//   last=0 is a no-op.
//   rsp channel: after a last transaction, eight transactions carry the
//   digest words H0..H7 (word_index 0..7, last_word on the eighth).
// Timing:
//   A byte that does not fill the block leaves the sequencer idle. The
//   64th byte of a block starts a compression: a load step, 64 rounds (one
//   round per cycle in the shared round unit) and a fold step.
//   A last transaction pads, compresses one or two blocks, then presents
//   eight digest words, one per cycle when the receiver keeps rsp_ready
//   high. req_ready is low while the sequencer is busy.
// Reset: synchronous, clears the sequencer and length, restores the
//   initial hash. Block buffer contents are undefined until written.
// Stall: rsp_valid holds with stable payload until rsp_ready; the block
//   stays busy until all eight words are taken.
`default_nettype none
module sha256_message_hasher (
   input  wire logic clock,
   input  wire logic reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_FOLD  = 7'b0001000,
      ST_PAD   = 7'b0010000,
      ST_LEN   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   sha_pkg::word_type  buf_ff [16];
   sha_pkg::word_type  buf_in [16];
   logic [63:0]        len_ff;
   logic [5:0]         round_ff;
   logic [3:0]         padw_ff;   // next word to clear during padding
   logic               fin_ff;    // compressing a final block
   logic               two_ff;    // another final block follows this one
   logic               lead_ff;   // that block opens with the 0x80 marker
   logic [2:0]         out_ff;
   sha_pkg::rnd_ctl_type ctl;
   sha_pkg::word_type  rd_word;
   logic               acc;
   logic [5:0]         pos;
   logic [5:0]         pos_nxt;   // byte position after this transaction's byte

   assign req.ready = (state_ff == ST_IDLE);
   assign acc       = req.valid && req.ready;
   assign pos       = len_ff[8:3];
   assign pos_nxt   = pos + {5'd0, req.payload.has_byte};

   sha_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .round_idx  (round_ff),
      .block_words(buf_ff),
      .rd_index   (out_ff),
      .rd_word    (rd_word)
   );

   always_comb begin
      ctl        = '0;
      ctl.start  = (state_ff == ST_LOAD);
      ctl.step   = (state_ff == ST_ROUND);
      ctl.finish = (state_ff == ST_FOLD);
      ctl.reinit = (state_ff == ST_OUT) && rsp.ready && (out_ff == 3'd7);
   end

   assign rsp.valid   = (state_ff == ST_OUT);
   assign rsp.payload = {rd_word, out_ff, (out_ff == 3'd7)};

   // buffer: byte writes, padding word clears, length words, extra padding block
   always_comb begin
      buf_in = buf_ff;
      if (acc) begin
         if (req.payload.has_byte) begin
            buf_in[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = req.payload.data_byte;
         end
         if (req.payload.last && !(req.payload.has_byte && pos == 6'd63)) begin
            // keep bytes up to the marker, clear the rest of its word
            buf_in[pos_nxt[5:2]] = buf_in[pos_nxt[5:2]]
                                 & (32'hffffffff << {~pos_nxt[1:0], 3'b000});
            buf_in[pos_nxt[5:2]][{~pos_nxt[1:0], 3'b000} +: 8] = sha_pkg::PAD_BYTE;
         end
      end else if (state_ff == ST_PAD) begin
         buf_in[padw_ff] = '0;
      end else if (state_ff == ST_LEN) begin
         buf_in[14] = len_ff[63:32];
         buf_in[15] = len_ff[31:0];
      end else if (state_ff == ST_FOLD && fin_ff && two_ff) begin
         // extra padding block: zeros, marker first when the data ended on a full block
         for (int i = 0; i < 16; i++) buf_in[i] = '0;
         if (lead_ff) buf_in[0] = {sha_pkg::PAD_BYTE, 24'h0};
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (acc) begin
            if (req.payload.has_byte && pos == 6'd63) state_in = ST_LOAD;
            else if (req.payload.last)
               // marker in the last word leaves nothing to clear
               state_in = (pos_nxt[5:2] == 4'd15) ? ST_LOAD : ST_PAD;
         end
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_FOLD;
         ST_FOLD:  begin
            if (!fin_ff) state_in = ST_IDLE;
            else if (two_ff) state_in = ST_LEN;
            else state_in = ST_OUT;
         end
         ST_PAD:   if (padw_ff == 4'd15) state_in = two_ff ? ST_LOAD : ST_LEN;
         ST_LEN:   state_in = ST_LOAD;
         ST_OUT:   if (rsp.ready && out_ff == 3'd7) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         round_ff <= '0;
         padw_ff  <= '0;
         fin_ff   <= 1'b0;
         two_ff   <= 1'b0;
         lead_ff  <= 1'b0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: if (acc) begin
               len_ff <= len_ff + (req.payload.has_byte ? 64'd8 : 64'd0);
               fin_ff <= req.payload.last;
               // pad word after the one holding 0x80; a full block defers pad
               if (req.payload.has_byte && pos == 6'd63) begin
                  padw_ff <= 4'd0;
                  two_ff  <= req.payload.last;
                  lead_ff <= req.payload.last;
               end else begin
                  padw_ff <= pos_nxt[5:2] + 4'd1;
                  two_ff  <= (pos_nxt >= 6'd56);
                  lead_ff <= 1'b0;
               end
            end
            ST_ROUND: round_ff <= round_ff + 6'd1;
            ST_FOLD:  if (fin_ff && two_ff) begin
               two_ff  <= 1'b0;
               lead_ff <= 1'b0;
            end
            ST_PAD:   padw_ff <= padw_ff + 4'd1;
            ST_OUT:   if (rsp.ready) begin
               out_ff <= out_ff + 3'd1;
               if (out_ff == 3'd7) len_ff <= '0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[hw/rtl/sha_checker.sv]
// Port-level checker for the SHA-256 hasher, bound to the top level.
`default_nettype none
module sha_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire sha_pkg::rsp_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while responding");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_word
      |=> rsp_valid && rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1)
      else $error("digest index did not advance");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_word == (rsp_payload.word_index == 3'd7)))
      else $error("last_word mismatch");
endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_payload(rsp.payload)
);
`default_nettype wire
